FILE: src/bit_parallel_approx_string_match_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the approximate string matcher
// Shared wrappers so every check uses the same clocking and reset handling.
// ----------------------------------------------------------------------------
`ifndef BIT_PARALLEL_APPROX_STRING_MATCH_MACROS_SVH
`define BIT_PARALLEL_APPROX_STRING_MATCH_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define BPAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BPAM_ASSERT_NEVER(lbl, cond, msg) \
  `BPAM_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/bpam_pkg.sv
// ----------------------------------------------------------------------------
// bpam_pkg
// Constants and types of the bit-vector approximate string matcher.
// ----------------------------------------------------------------------------
package bpam_pkg;

  localparam int unsigned PatternMax   = 64;
  localparam int unsigned AlphabetSize = 128;
  localparam int unsigned SymW         = $clog2(AlphabetSize);
  localparam int unsigned IdxW         = $clog2(PatternMax);
  localparam int unsigned LenW         = 7;
  localparam int unsigned PosW         = 32;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutDataW     = 40;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = QPtrW + 1;

  typedef enum logic {
    KIND_PATTERN = 1'b0,
    KIND_TEXT    = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_MAX_DISTANCE   = 1'b1
  } cfg_reg_e;

  // match in bit 0, distance above it, position on top
  typedef struct packed {
    logic [PosW-1:0] text_position;
    logic [LenW-1:0] distance;
    logic            match;
  } result_t;

endpackage

FILE: src/bit_parallel_approx_string_match.sv
// ----------------------------------------------------------------------------
// bit_parallel_approx_string_match
// Myers bit-vector approximate matcher, pattern up to 64 symbols, with the
// per-symbol match masks held in a 128 x 64 synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  s_axis   | in  | pattern load or text symbol (kind in tuser)
//  m_axis   | out | one result per text symbol
//  cfg      | in  | register write, no handshake
//
//  Each beat is registered at the mask-memory read, then runs the 64-bit add
//  recurrence or writes a pattern bit back (last write forwarded to the next
//  read). One beat per cycle is taken while s_axis_tready is high.
//  Results go through a four-entry queue; s_axis_tready drops once the queue
//  and the text beat in flight fill it, so m_axis_tready never reaches it.
//  Reset clears the mask valid bits at once; no sweep is needed.
// ----------------------------------------------------------------------------
module bit_parallel_approx_string_match (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [6:0] symbol, [7] first, [13:8] pattern_index, [15:14] zero
  input  logic [bpam_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] match, [7:1] distance, [39:8] text_position
  output logic [bpam_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [bpam_pkg::LenW-1:0]         cfg_data_i
);

  localparam int unsigned Pm = bpam_pkg::PatternMax;

  logic                          in_acc;
  logic [bpam_pkg::SymW-1:0]     in_sym;

  logic [bpam_pkg::LenW-1:0]     len_q, maxd_q;

  logic                          s1_vld_q, s1_kind_q, s1_first_q;
  logic [bpam_pkg::SymW-1:0]     s1_sym_q;
  logic [bpam_pkg::IdxW-1:0]     s1_idx_q;

  logic [Pm-1:0]                 peq_mem_q [bpam_pkg::AlphabetSize];
  logic [Pm-1:0]                 rdata_q;
  logic [bpam_pkg::AlphabetSize-1:0] ent_vld_q, ent_vld_d;
  logic                          fwd_vld_q;
  logic [bpam_pkg::SymW-1:0]     fwd_sym_q;
  logic [Pm-1:0]                 fwd_data_q;

  logic [Pm-1:0]                 entry, new_entry;
  logic                          pat_wr, txt_go;

  logic [Pm-1:0]                 pv_q, pv_d, mv_q, mv_d;
  logic [bpam_pkg::LenW-1:0]     score_q, score_d, eff_len, sc_base, sc_inc;
  logic [bpam_pkg::PosW-1:0]     pos_q, pos_base;
  logic [bpam_pkg::IdxW-1:0]     sel_idx;
  logic [Pm-1:0]                 pv, mv, eq, xv, xh, ph, mh, phs, mhs;
  bpam_pkg::result_t             res;

  bpam_pkg::result_t             q_mem_q [bpam_pkg::QDepth];
  logic [bpam_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [bpam_pkg::QCntW-1:0]    cnt_q, cnt_d;
  logic                          q_pop;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= bpam_pkg::LenW'(Pm);
      maxd_q <= '0;
    end else if (cfg_we_i) begin
      case (bpam_pkg::cfg_reg_e'(cfg_addr_i))
        bpam_pkg::CFG_PATTERN_LENGTH: len_q  <= cfg_data_i;
        bpam_pkg::CFG_MAX_DISTANCE:   maxd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      eff_len = bpam_pkg::LenW'(1);
    end else if (len_q > bpam_pkg::LenW'(Pm)) begin
      eff_len = bpam_pkg::LenW'(Pm);
    end else begin
      eff_len = len_q;
    end
  end
  assign sel_idx = bpam_pkg::IdxW'(eff_len - bpam_pkg::LenW'(1));

  // ---------------- input stage ----------------
  assign q_pop         = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q + bpam_pkg::QCntW'(txt_go))
                         <= bpam_pkg::QCntW'(bpam_pkg::QDepth - 1);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_sym        = s_axis_tdata[bpam_pkg::SymW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q  <= s_axis_tuser;
      s1_sym_q   <= in_sym;
      s1_first_q <= s_axis_tdata[7];
      s1_idx_q   <= s_axis_tdata[8 +: bpam_pkg::IdxW];
    end
  end

  // ---------------- mask memory ----------------
  assign pat_wr = s1_vld_q && (bpam_pkg::kind_e'(s1_kind_q) == bpam_pkg::KIND_PATTERN);
  assign txt_go = s1_vld_q && (bpam_pkg::kind_e'(s1_kind_q) == bpam_pkg::KIND_TEXT);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= peq_mem_q[in_sym];
    end
    if (pat_wr) begin
      peq_mem_q[s1_sym_q] <= new_entry;
    end
  end

  always_comb begin
    if (!ent_vld_q[s1_sym_q]) begin
      entry = '0;
    end else if (fwd_vld_q && (fwd_sym_q == s1_sym_q)) begin
      entry = fwd_data_q;
    end else begin
      entry = rdata_q;
    end
    new_entry = (s1_first_q ? '0 : entry) | (Pm'(1) << s1_idx_q);
    ent_vld_d = ent_vld_q;
    if (pat_wr) begin
      if (s1_first_q) begin
        ent_vld_d = '0;
      end
      ent_vld_d[s1_sym_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      fwd_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= ent_vld_d;
      fwd_vld_q <= pat_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_wr) begin
      fwd_sym_q  <= s1_sym_q;
      fwd_data_q <= new_entry;
    end
  end

  // ---------------- search recurrence ----------------
  always_comb begin
    pv       = s1_first_q ? '1 : pv_q;
    mv       = s1_first_q ? '0 : mv_q;
    sc_base  = s1_first_q ? eff_len : score_q;
    pos_base = s1_first_q ? '0 : pos_q;
    eq       = entry;
    xv       = eq | mv;
    xh       = (((eq & pv) + pv) ^ pv) | eq;
    ph       = mv | ~(xh | pv);
    mh       = pv & xh;
    phs      = ph << 1;
    mhs      = mh << 1;
    pv_d     = mhs | ~(xv | phs);
    mv_d     = phs & xv;
    sc_inc   = (ph[sel_idx] && (sc_base < bpam_pkg::LenW'(Pm)))
               ? sc_base + bpam_pkg::LenW'(1) : sc_base;
    score_d  = (mh[sel_idx] && (sc_inc != '0)) ? sc_inc - bpam_pkg::LenW'(1) : sc_inc;
    res.match         = score_d <= maxd_q;
    res.distance      = score_d;
    res.text_position = pos_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '1;
      mv_q    <= '0;
      score_q <= bpam_pkg::LenW'(Pm);
      pos_q   <= '0;
    end else if (txt_go) begin
      pv_q    <= pv_d;
      mv_q    <= mv_d;
      score_q <= score_d;
      pos_q   <= pos_base + bpam_pkg::PosW'(1);
    end
  end

  // ---------------- result queue ----------------
  always_ff @(posedge clk_i) begin
    if (txt_go) begin
      q_mem_q[wr_ptr_q] <= res;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (txt_go && !q_pop) begin
      cnt_d = cnt_q + bpam_pkg::QCntW'(1);
    end else if (!txt_go && q_pop) begin
      cnt_d = cnt_q - bpam_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (txt_go) begin
        wr_ptr_q <= wr_ptr_q + bpam_pkg::QPtrW'(1);
      end
      if (q_pop) begin
        rd_ptr_q <= rd_ptr_q + bpam_pkg::QPtrW'(1);
      end
    end
  end

  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tdata  = q_mem_q[rd_ptr_q];

endmodule

FILE: src/bpam_checker.sv
// ----------------------------------------------------------------------------
// bpam_checker
// Port-level checks of the approximate string matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "bit_parallel_approx_string_match_macros.svh"

module bpam_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic                          s_axis_tuser,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [bpam_pkg::OutDataW-1:0] m_axis_tdata
);

  `BPAM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")
  `BPAM_ASSERT_NEVER(a_dist_range, m_axis_tvalid && (m_axis_tdata[7:1] > 7'd64), "distance above pattern maximum")
  `BPAM_ASSERT(a_out_cause, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tuser, 2), "result without a text beat two cycles earlier")
  `BPAM_ASSERT(a_stall_full, !s_axis_tready |-> m_axis_tvalid, "input stalled with no result pending")

endmodule

bind bit_parallel_approx_string_match bpam_checker u_bpam_checker (.*);

FILE: verif/tb_bit_parallel_approx_string_match.sv
// ----------------------------------------------------------------------------
// tb_bit_parallel_approx_string_match
// Self-checking bench for the bit-vector approximate matcher. A directed list
// of beats and register writes is followed by random phases. Each phase may
// set the length and threshold registers and mostly reloads the pattern, then
// streams text built from that pattern with insertions, plus noise. Every
// text beat but a typed row is predicted by a local column-update model.
// Each result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bit_parallel_approx_string_match;
  import bpam_pkg::*;

  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomBeats = 1200;
  localparam int unsigned NumRows     = 25;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_REG  = 1'b1
  } row_op_e;

  typedef struct packed {
    row_op_e    op;
    kind_e      kind;
    cfg_reg_e   reg_sel;
    logic [6:0] val;
    logic       first;
    logic [5:0] pidx;
    logic       typed;
    result_t    want;
  } stim_row_t;

  // typed results: reset state, empty mask table, score stays at full length
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd0,   1'b0, 6'd0,  1'b1,
      result_t'{32'd0, 7'd64, 1'b0}},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd127, 1'b1, 6'd63, 1'b1,
      result_t'{32'd0, 7'd64, 1'b0}},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd5,   1'b0, 6'd0,  1'b1,
      result_t'{32'd1, 7'd64, 1'b0}},
    '{ROW_REG,  KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd3,   1'b0, 6'd0,  1'b0, '0},
    '{ROW_REG,  KIND_TEXT,    CFG_MAX_DISTANCE,   7'd1,   1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_PATTERN, CFG_PATTERN_LENGTH, 7'd97,  1'b1, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_PATTERN, CFG_PATTERN_LENGTH, 7'd98,  1'b0, 6'd1,  1'b0, '0},
    '{ROW_BEAT, KIND_PATTERN, CFG_PATTERN_LENGTH, 7'd99,  1'b0, 6'd2,  1'b0, '0},
    '{ROW_BEAT, KIND_PATTERN, CFG_PATTERN_LENGTH, 7'd127, 1'b0, 6'd63, 1'b0, '0},
    '{ROW_BEAT, KIND_PATTERN, CFG_PATTERN_LENGTH, 7'd0,   1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd120, 1'b1, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd97,  1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd98,  1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd99,  1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd97,  1'b1, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd99,  1'b0, 6'd0,  1'b0, '0},
    '{ROW_REG,  KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd0,   1'b0, 6'd0,  1'b0, '0},
    '{ROW_REG,  KIND_TEXT,    CFG_MAX_DISTANCE,   7'd127, 1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd97,  1'b1, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd127, 1'b0, 6'd0,  1'b0, '0},
    '{ROW_REG,  KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd127, 1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd0,   1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd98,  1'b1, 6'd0,  1'b0, '0},
    '{ROW_REG,  KIND_TEXT,    CFG_MAX_DISTANCE,   7'd64,  1'b0, 6'd0,  1'b0, '0},
    '{ROW_BEAT, KIND_TEXT,    CFG_PATTERN_LENGTH, 7'd122, 1'b0, 6'd0,  1'b0, '0}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic                  cfg_addr_i    = 1'b0;
  logic [LenW-1:0]       cfg_data_i    = '0;

  // local copy of the matcher state
  logic [63:0]           mask_table [AlphabetSize];
  logic [63:0]           vp_vec;
  logic [63:0]           vn_vec;
  int unsigned           cur_score;
  logic [31:0]           cur_pos;
  logic [6:0]            len_reg;
  logic [6:0]            maxd_reg;

  result_t               pending_results [$];
  logic                  typed_on      = 1'b0;
  result_t               typed_want    = '0;
  logic                  in_taken      = 1'b0;
  logic                  quiet         = 1'b0;
  int unsigned           beats_sent    = 0;
  int unsigned           err_count     = 0;
  int unsigned           cycle_count   = 0;

  bit_parallel_approx_string_match DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_length(input logic [6:0] len);
    if (len == 0) return 1;
    if (len > PatternMax) return PatternMax;
    return len;
  endfunction

  task automatic load_pattern_bit(input logic [6:0] sym, input logic first,
                                  input logic [5:0] pidx);
    if (first) begin
      foreach (mask_table[i]) mask_table[i] = '0;
    end
    mask_table[sym][pidx] = 1'b1;
  endtask

  // one column of the bit-vector recurrence, score read at bit len-1
  task automatic search_column(input logic [6:0] sym, input logic first,
                               output result_t res);
    logic [63:0] eq, xv, xh, ph, mh, phs, mhs, sel;
    int unsigned len;
    len = active_length(len_reg);
    if (first) begin
      vp_vec    = '1;
      vn_vec    = '0;
      cur_score = len;
      cur_pos   = '0;
    end
    eq  = mask_table[sym];
    sel = 64'd1 << (len - 1);
    xv  = eq | vn_vec;
    xh  = (((eq & vp_vec) + vp_vec) ^ vp_vec) | eq;
    ph  = vn_vec | ~(xh | vp_vec);
    mh  = vp_vec & xh;
    if ((ph & sel) != 0 && cur_score < PatternMax) cur_score = cur_score + 1;
    if ((mh & sel) != 0 && cur_score > 0) cur_score = cur_score - 1;
    phs    = ph << 1;
    mhs    = mh << 1;
    vp_vec = mhs | ~(xv | phs);
    vn_vec = phs & xv;
    res.match         = (cur_score <= maxd_reg);
    res.distance      = 7'(cur_score);
    res.text_position = cur_pos;
    cur_pos = cur_pos + 1;
  endtask

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    result_t res;
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          err_count = err_count + 1;
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got.match !== want.match) begin
            err_count = err_count + 1;
            $display("%0t: match mismatch, expected %0d, actual %0d",
                     $time, want.match, got.match);
          end
          if (got.distance !== want.distance) begin
            err_count = err_count + 1;
            $display("%0t: distance mismatch, expected %0d, actual %0d",
                     $time, want.distance, got.distance);
          end
          if (got.text_position !== want.text_position) begin
            err_count = err_count + 1;
            $display("%0t: text_position mismatch, expected %0d, actual %0d",
                     $time, want.text_position, got.text_position);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          CFG_PATTERN_LENGTH: len_reg  = cfg_data_i;
          CFG_MAX_DISTANCE:   maxd_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_taken) begin
        if (kind_e'(s_axis_tuser) == KIND_TEXT) begin
          search_column(s_axis_tdata[6:0], s_axis_tdata[7], res);
          pending_results.push_back(typed_on ? typed_want : res);
        end else begin
          load_pattern_bit(s_axis_tdata[6:0], s_axis_tdata[7], s_axis_tdata[13:8]);
        end
      end
    end
  end

  // sink back-pressure in bursts
  always begin
    int unsigned n;
    @(negedge clk_i);
    if (quiet || $urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      n = $urandom_range(1, 30);
    end else begin
      m_axis_tready <= 1'b0;
      n = $urandom_range(1, 17);
    end
    repeat (n - 1) @(negedge clk_i);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high
  task automatic send_beat(input kind_e kind, input logic [6:0] sym, input logic first,
                           input logic [5:0] pidx, input logic typed, input result_t want);
    if (beats_sent >= NumRows + RandomBeats - 150) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, pidx, first, sym};
    typed_on      <= typed;
    typed_want    <= want;
    do @(negedge clk_i); while (!in_taken);
    beats_sent = beats_sent + 1;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [6:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    logic [6:0]  pat [PatternMax];
    logic [6:0]  new_len;
    logic [6:0]  sym;
    logic        restart;
    int unsigned plen, base, alph, j, n, r;
    foreach (mask_table[i]) mask_table[i] = '0;
    len_reg   = 7'd64;
    maxd_reg  = 7'd0;
    vp_vec    = '1;
    vn_vec    = '0;
    cur_score = PatternMax;
    cur_pos   = '0;
    new_len   = 7'd64;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].op == ROW_REG) begin
        write_reg(DirectedRows[i].reg_sel, DirectedRows[i].val);
        if (DirectedRows[i].reg_sel == CFG_PATTERN_LENGTH) new_len = DirectedRows[i].val;
      end else begin
        send_beat(DirectedRows[i].kind, DirectedRows[i].val, DirectedRows[i].first,
                  DirectedRows[i].pidx, DirectedRows[i].typed, DirectedRows[i].want);
      end
    end

    plen = 0;
    while (beats_sent < NumRows + RandomBeats) begin
      if (plen == 0 || $urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0:       new_len = 7'd0;
          1:       new_len = 7'd1;
          2:       new_len = 7'd64;
          3:       new_len = 7'($urandom_range(65, 127));
          4:       new_len = 7'd127;
          default: new_len = 7'($urandom_range(1, 16));
        endcase
        write_reg(CFG_PATTERN_LENGTH, new_len);
      end
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 7))
          0:       write_reg(CFG_MAX_DISTANCE, 7'd0);
          1:       write_reg(CFG_MAX_DISTANCE, 7'd64);
          2:       write_reg(CFG_MAX_DISTANCE, 7'd127);
          3:       write_reg(CFG_MAX_DISTANCE, 7'($urandom_range(65, 127)));
          default: write_reg(CFG_MAX_DISTANCE, 7'($urandom_range(0, 3)));
        endcase
      end

      // mostly reload; otherwise keep the old table
      if (plen == 0 || $urandom_range(0, 3) != 0) begin
        plen = active_length(new_len);
        base = $urandom_range(0, 119);
        alph = $urandom_range(2, 8);
        for (int i = 0; i < plen; i++) begin
          pat[i] = 7'(base + $urandom_range(0, alph - 1));
          send_beat(KIND_PATTERN, pat[i], i == 0 && $urandom_range(0, 7) != 0,
                    6'(i), 1'b0, '0);
        end
      end

      restart = ($urandom_range(0, 4) != 0);
      n = $urandom_range(60, 160);
      j = 0;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          send_beat(kind_e'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    $urandom_range(0, 7) == 0, 6'($urandom_range(0, 63)), 1'b0, '0);
        end else begin
          if (r < 12) begin
            sym = pat[j];
            j = (j + 1) % plen;
          end else if (r < 18) begin
            sym = 7'(base + $urandom_range(0, alph - 1));
          end else begin
            sym = 7'($urandom_range(0, 127));
          end
          send_beat(KIND_TEXT, sym, (k == 0 && restart) || $urandom_range(0, 63) == 0,
                    6'($urandom_range(0, 63)), 1'b0, '0);
        end
      end
    end

    quiet = 1'b1;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: bit_parallel_approx_string_match.f
+incdir+src
src/bpam_pkg.sv
src/bit_parallel_approx_string_match.sv
src/bpam_checker.sv
verif/tb_bit_parallel_approx_string_match.sv
